// File: rtl/core/dbla_pkg.sv
// Shared types and constants for the double-buffered line assembler.
// No dependencies; every other file imports this package.
`default_nettype none

package dbla_pkg;

  // Bytes per line store; a line holds at most LINE_BYTES-1 counted bytes.
  localparam int unsigned LINE_BYTES = 64;
  localparam int unsigned ADDR_W     = $clog2(LINE_BYTES);
  localparam int unsigned FILL_W     = 7;

  localparam logic [ADDR_W-1:0] LAST_CNT = ADDR_W'(LINE_BYTES - 1);

  // Request function codes.
  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_LINE  = 2'd1;
  localparam logic [1:0] FUNC_CHAR  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]        out_char;
    logic              is_last;
    logic              line_ready;
    logic [FILL_W-1:0] fill_count;
    logic              spare_ready;
  } rsp_t;

  // Store status as seen after the last request.
  typedef struct packed {
    logic              line_ready;
    logic [ADDR_W-1:0] fill_count;
    logic              spare_ready;
  } stat_t;

  // Work handed from the store control to the reader at accept.
  typedef struct packed {
    logic              imm;   // single result, char 0
    logic              line;  // stream a line
    logic              chr;   // return first char
    logic [ADDR_W-1:0] len;
    logic              sel;   // physical RAM to read
  } rd_cmd_t;

  // Write port shared by both RAMs.
  typedef struct packed {
    logic [1:0]        en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

endpackage

`default_nettype wire

// File: rtl/core/double_buffered_line_assembler_top.sv
// Top level of the double-buffered line assembler.
// Depends on dbla_pkg, dbla_ram, dbla_ctrl and dbla_reader.
`default_nettype none

// A request is taken on a rising edge with start high and busy low. Every
// request produces one or more results, each shown for exactly one cycle with
// rsp_valid_o high; the receiver cannot stall, so it must take each result in
// the cycle it appears. Receive, clear and reads with nothing to return give
// their single result in the cycle after the request and leave busy low, so
// such requests can be issued every cycle. A read-char on a finished line
// keeps busy high while it does one RAM read and returns its result in the
// following cycle. A read-line that streams n characters keeps busy high
// until all are out: the single read port of the line RAM delivers one stored
// character per cycle, and one extra entry (or a final flush state) is needed
// to know which character is the last. The status fields on every result show
// the store state after the request. Main and spare lines live in two RAMs;
// promoting spare to main swaps their roles instead of copying data.

module double_buffered_line_assembler_top import dbla_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      rsp_valid_o,
  output rsp_t      rsp_o
);

  logic              accept;
  rd_cmd_t           cmd;
  stat_t             stat;
  wr_t               wr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata0, rdata1;

  assign accept = start && !busy;

  dbla_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .cmd_o    (cmd),
    .stat_o   (stat),
    .wr_o     (wr)
  );

  // Two physical line stores; the control block tracks which one is main.
  dbla_ram u_ram0 (
    .clk_i   (clk_i),
    .we_i    (wr.en[0]),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  dbla_ram u_ram1 (
    .clk_i   (clk_i),
    .we_i    (wr.en[1]),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  dbla_reader u_reader (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_i      (stat),
    .rdata0_i    (rdata0),
    .rdata1_i    (rdata1),
    .raddr_o     (raddr),
    .busy_o      (busy),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/dbla_ram.sv
// One line store: synchronous RAM, one write and one read port, registered read.
// Depends on dbla_pkg.
`default_nettype none

module dbla_ram import dbla_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0] mem [LINE_BYTES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/dbla_ctrl.sv
// Store control: counts, done flags and main/spare role bit; issues RAM writes.
// Depends on dbla_pkg.
`default_nettype none

module dbla_ctrl import dbla_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic accept_i,
  input  wire req_t req_i,
  output rd_cmd_t   cmd_o,
  output stat_t     stat_o,
  output wr_t       wr_o
);

  typedef struct packed {
    logic [ADDR_W-1:0] cnt;
    logic              done;
    logic              we;
  } take_t;

  logic [ADDR_W-1:0] m_cnt_q, m_cnt_d, s_cnt_q, s_cnt_d;
  logic              m_done_q, m_done_d, s_done_q, s_done_d;
  logic              sel_q, sel_d;   // physical RAM holding main
  logic              term;
  logic              promote_ok;
  take_t             tk;
  logic [ADDR_W-1:0] t_cnt;
  logic              t_done;

  function automatic take_t take_byte(logic [ADDR_W-1:0] c, logic dn, logic is_t);
    take_t t;
    t.cnt  = c;
    t.done = dn;
    t.we   = 1'b0;
    if (c < LAST_CNT) begin
      if (is_t) begin
        if (c != '0) begin
          t.we   = 1'b1;
          t.done = 1'b1;
          t.cnt  = c + ADDR_W'(1);
        end
      end else begin
        t.we  = 1'b1;
        t.cnt = c + ADDR_W'(1);
      end
    end else begin
      t.done = 1'b1;  // full: byte dropped, line forced closed
    end
    return t;
  endfunction

  assign term = (req_i.rx_byte == CHAR_LF) || (req_i.rx_byte == CHAR_CR) ||
                (req_i.rx_byte == CHAR_NUL);
  assign promote_ok = (s_cnt_q != '0);

  always_comb begin
    m_cnt_d    = m_cnt_q;
    m_done_d   = m_done_q;
    s_cnt_d    = s_cnt_q;
    s_done_d   = s_done_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    wr_o       = '0;
    wr_o.data  = term ? CHAR_NUL : req_i.rx_byte;
    t_cnt      = promote_ok ? s_cnt_q : m_cnt_q;
    t_done     = promote_ok ? s_done_q : m_done_q;
    tk         = '0;
    if (accept_i) begin
      case (req_i.func)
        FUNC_RX: begin
          cmd_o.imm = 1'b1;
          if (!m_done_q) begin
            if (promote_ok) begin
              sel_d    = ~sel_q;
              s_cnt_d  = '0;
              s_done_d = 1'b0;
            end
            tk       = take_byte(t_cnt, t_done, term);
            m_cnt_d  = tk.cnt;
            m_done_d = tk.done;
            wr_o.addr = t_cnt;
            wr_o.en[sel_d] = tk.we;
          end else if (!s_done_q) begin
            tk       = take_byte(s_cnt_q, s_done_q, term);
            s_cnt_d  = tk.cnt;
            s_done_d = tk.done;
            wr_o.addr = s_cnt_q;
            wr_o.en[~sel_q] = tk.we;
          end
        end
        FUNC_LINE, FUNC_CHAR: begin
          cmd_o.len = m_cnt_q;
          cmd_o.sel = sel_q;
          if (req_i.func == FUNC_LINE) begin
            cmd_o.line = (m_cnt_q != '0);
            cmd_o.imm  = (m_cnt_q == '0);
          end else begin
            cmd_o.chr  = m_done_q && (m_cnt_q != '0);
            cmd_o.imm  = !(m_done_q && (m_cnt_q != '0));
          end
          if (cmd_o.line || cmd_o.chr) begin
            // empty main, then promote a non-empty spare
            if (promote_ok) begin
              sel_d    = ~sel_q;
              m_cnt_d  = s_cnt_q;
              m_done_d = s_done_q;
              s_cnt_d  = '0;
              s_done_d = 1'b0;
            end else begin
              m_cnt_d  = '0;
              m_done_d = 1'b0;
            end
          end
        end
        FUNC_CLEAR: begin
          cmd_o.imm = 1'b1;
          m_cnt_d   = '0;
          m_done_d  = 1'b0;
          s_cnt_d   = '0;
          s_done_d  = 1'b0;
        end
        default: begin
          cmd_o.imm = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_cnt_q  <= '0;
      m_done_q <= 1'b0;
      s_cnt_q  <= '0;
      s_done_q <= 1'b0;
      sel_q    <= 1'b0;
    end else begin
      m_cnt_q  <= m_cnt_d;
      m_done_q <= m_done_d;
      s_cnt_q  <= s_cnt_d;
      s_done_q <= s_done_d;
      sel_q    <= sel_d;
    end
  end

  assign stat_o.line_ready  = m_done_q;
  assign stat_o.fill_count  = m_cnt_q;
  assign stat_o.spare_ready = s_done_q;

endmodule

`default_nettype wire

// File: rtl/core/dbla_reader.sv
// Reader: walks the main RAM one entry a cycle and drives the result strobe.
// Depends on dbla_pkg.
`default_nettype none

module dbla_reader import dbla_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rd_cmd_t           cmd_i,
  input  wire stat_t             stat_i,
  input  wire logic [7:0]        rdata0_i,
  input  wire logic [7:0]        rdata1_i,
  output logic      [ADDR_W-1:0] raddr_o,
  output logic                   busy_o,
  output logic                   rsp_valid_o,
  output rsp_t                   rsp_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LINE  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_CHAR  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;     // index of the entry in rdata
  logic [ADDR_W-1:0] len_q, len_d;
  logic              rsel_q, rsel_d;
  logic [7:0]        pend_q, pend_d;   // char held until its successor is seen
  logic              vld_q, vld_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;
  logic [7:0]        rdata;
  logic              more;

  assign rdata   = rsel_q ? rdata1_i : rdata0_i;
  assign raddr_o = (state_q == ST_LINE) ? ptr_q + ADDR_W'(1) : '0;
  assign busy_o  = (state_q != ST_IDLE);
  assign more    = ({1'b0, ptr_q} + (ADDR_W + 1)'(1)) < {1'b0, len_q};

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    len_d   = len_q;
    rsel_d  = rsel_q;
    pend_d  = pend_q;
    vld_d   = 1'b0;
    char_d  = char_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.imm) begin
          vld_d  = 1'b1;
          char_d = CHAR_NUL;
          last_d = 1'b1;
        end
        if (cmd_i.line) begin
          state_d = ST_LINE;
          ptr_d   = '0;
          len_d   = cmd_i.len;
          rsel_d  = cmd_i.sel;
        end
        if (cmd_i.chr) begin
          state_d = ST_CHAR;
          rsel_d  = cmd_i.sel;
        end
      end
      ST_LINE: begin
        if (rdata == CHAR_NUL) begin
          vld_d   = 1'b1;
          char_d  = (ptr_q == '0) ? CHAR_NUL : pend_q;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (ptr_q != '0) begin
            vld_d  = 1'b1;
            char_d = pend_q;
            last_d = 1'b0;
          end
          pend_d = rdata;
          if (more) begin
            ptr_d = ptr_q + ADDR_W'(1);
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        vld_d   = 1'b1;
        char_d  = pend_q;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_CHAR: begin
        vld_d   = 1'b1;
        char_d  = rdata;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
      rsel_q  <= 1'b0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      rsel_q  <= rsel_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    pend_q <= pend_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign rsp_valid_o          = vld_q;
  assign rsp_o.out_char       = char_q;
  assign rsp_o.is_last        = last_q;
  assign rsp_o.line_ready     = stat_i.line_ready;
  assign rsp_o.fill_count     = FILL_W'(stat_i.fill_count);
  assign rsp_o.spare_ready    = stat_i.spare_ready;

endmodule

`default_nettype wire
